// File: design/rk4tc_pkg.sv
// ----------------------------------------------------------------------------
// rk4tc_pkg: shared definitions for the RK4 two-compartment step unit
// Widths, register indexes, request kinds, sequencer phases and states.
// ----------------------------------------------------------------------------
package rk4tc_pkg;

  localparam int AMT_W   = 32;  // amount width, signed Q16.16
  localparam int RATE_W  = 16;  // rate width, unsigned Q0.16
  localparam int STEP_W  = 24;  // step size width, unsigned Q8.16
  localparam int SHIFT_W = 16;  // fraction bits of rates and step size
  localparam int PROD_W  = AMT_W + STEP_W + 1;  // signed product width
  localparam int ACC_W   = 50;  // derivative accumulator, two rate products
  localparam int SUM_W   = 35;  // weighted slope sum, up to six slopes
  localparam int DIVN_W  = 36;  // divider numerator, whole digits
  localparam int DIG_W   = 4;   // quotient bits retired per cycle
  localparam int DIV_STEPS = DIVN_W / DIG_W;
  localparam int DCNT_W  = 4;
  localparam int QUO_W   = 34;  // signed quotient width
  localparam int QMAG_W  = 33;  // quotient magnitude width
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_B2T = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ELIM = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_T2B = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 8'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Phases of one slope evaluation on the shared multiplier.
  localparam logic [2:0] PH_MUL_A = 3'd0;  // first rate product
  localparam logic [2:0] PH_MUL_B = 3'd1;  // second rate product
  localparam logic [2:0] PH_DIFF  = 3'd2;  // subtract second product
  localparam logic [2:0] PH_DERIV = 3'd3;  // round and clip derivative
  localparam logic [2:0] PH_MUL_H = 3'd4;  // scale by step size
  localparam logic [2:0] PH_SLOPE = 3'd5;  // round and clip slope

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOPE,
    ST_POINT,
    ST_DIV,
    ST_FIN
  } rk4tc_state_e;

endpackage

// File: design/rk4tc_div6.sv
// ----------------------------------------------------------------------------
// rk4tc_div6: digit-serial divide by six, rounding half away from zero
// Retires four quotient bits per cycle; the remainder never exceeds three bits.
// ----------------------------------------------------------------------------
module rk4tc_div6
  import rk4tc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SUM_W-1:0]  sum_i,
  output logic                     done_o,
  output logic signed [QUO_W-1:0]  quo_o
);

  logic                busy_q;
  logic                done_q;
  logic [DCNT_W-1:0]   cnt_q;
  logic [DIVN_W-1:0]   num_q;
  logic [2:0]          rem_q;
  logic [2:0]          rem_d;
  logic [QMAG_W-1:0]   quo_q;
  logic                neg_q;
  logic [DIG_W-1:0]    qdig;
  logic [3:0]          rw;
  logic signed [DIVN_W-1:0] sum_ext;
  logic [DIVN_W-1:0]   mag;

  // Magnitude plus three, so that truncation rounds half away from zero.
  assign sum_ext = DIVN_W'(sum_i);
  assign mag = (sum_i[SUM_W-1] ? DIVN_W'(-sum_ext) : DIVN_W'(sum_ext)) + DIVN_W'(3);

  always_comb begin
    rem_d = rem_q;
    qdig  = '0;
    rw    = '0;
    for (int i = 0; i < DIG_W; i++) begin
      rw = {rem_d, num_q[DIVN_W-1-i]};
      if (rw >= 4'd6) begin
        rw = rw - 4'd6;
        qdig[DIG_W-1-i] = 1'b1;
      end
      rem_d = rw[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= mag;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= sum_i[SUM_W-1];
    end else if (busy_q) begin
      num_q <= {num_q[DIVN_W-DIG_W-1:0], {DIG_W{1'b0}}};
      rem_q <= rem_d;
      quo_q <= {quo_q[QMAG_W-DIG_W-1:0], qdig};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// File: design/rk4_two_compartment_step_unit.sv
// ----------------------------------------------------------------------------
// rk4_two_compartment_step_unit: one RK4 step of a two-compartment model
// Blood and tissue amounts in Q16.16 advanced with rates kb, ke, kt and step h.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one request per beat. tuser selects the kind: a
//   load stores the two amounts in tdata, a step advances the stored amounts
//   by one fourth-order Runge-Kutta step. Every request yields exactly one
//   beat on the master stream with the amounts after the request and a flag
//   in tuser that is set when any intermediate or final value was clipped.
//   A load goes straight to the output register. A step runs eight slope
//   evaluations on one shared 32x24 multiplier, four point updates, then
//   the two divide-by-six digit units. tready stays low while a request
//   is in progress; one finished result may wait in the output register
//   while the next request is taken, and a stalled receiver holds the
//   block once that request completes. Rate registers are written on the
//   configuration channel, which is always ready; the user must write them
//   only while the block is idle, which the block does not enforce itself.
//   Reset restores the register defaults and clears both amounts.
// ----------------------------------------------------------------------------
module rk4_two_compartment_step_unit
  import rk4tc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // blood_load [31:0], tissue_load [63:32]
  input  logic [0:0]           s_axis_tuser,   // req_type [0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // blood_amount [31:0], tissue_amount [63:32]
  output logic [0:0]           m_axis_tuser,   // saturated [0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [STEP_W-1:0]    cfg_data_i
);

  localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
  localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

  function automatic logic [AMT_W:0] sat_amt(input logic signed [41:0] x);
    if (x > SAT_HI) begin
      return {1'b1, SAT_HI[AMT_W-1:0]};
    end else if (x < SAT_LO) begin
      return {1'b1, SAT_LO[AMT_W-1:0]};
    end
    return {1'b0, x[AMT_W-1:0]};
  endfunction

  rk4tc_state_e state_q, state_d;

  logic [2:0]  phase_q;
  logic [2:0]  slope_q;
  logic [1:0]  stage;
  logic        tissue;
  logic        last_stage;

  logic [RATE_W-1:0] kb_rate_q, ke_rate_q, kt_rate_q;
  logic [STEP_W-1:0] h_q;
  logic [RATE_W:0]   kout;

  logic signed [AMT_W-1:0] b_state_q, t_state_q;
  logic signed [AMT_W-1:0] pb_q, pt_q;
  logic signed [AMT_W-1:0] d_q;
  logic signed [AMT_W-1:0] kb_q, kt_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  sum_b_q, sum_t_q, sum_b_d, sum_t_d;
  logic                     sat_q;
  logic                     m_valid_q;
  logic [63:0]              m_data_q;
  logic                     m_sat_q;

  logic signed [AMT_W-1:0]  mul_x;
  logic [STEP_W-1:0]        mul_r;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [ACC_W:0]    acc_rnd;
  logic signed [PROD_W:0]   p_rnd;
  logic [AMT_W:0]           deriv_s, slope_s;
  logic signed [AMT_W:0]    inc_b, inc_t;
  logic [AMT_W:0]           pnt_b_s, pnt_t_s;
  logic signed [QUO_W-1:0]  quo_b, quo_t;
  logic [AMT_W:0]           fin_b_s, fin_t_s;
  logic                     div_done_b, div_done_t;

  logic in_acc;
  logic run_slope;
  logic run_point;
  logic div_start;
  logic fin_upd;
  logic out_load;

  assign stage      = slope_q[2:1];
  assign tissue     = slope_q[0];
  assign last_stage = (stage == 2'd3);
  assign kout       = {1'b0, kb_rate_q} + {1'b0, ke_rate_q};

  // Shared multiplier operand selection.
  always_comb begin
    if (phase_q == PH_MUL_H) begin
      mul_x = d_q;
      mul_r = h_q;
    end else if (phase_q == PH_MUL_A) begin
      mul_x = tissue ? pb_q : pt_q;
      mul_r = tissue ? STEP_W'(kb_rate_q) : STEP_W'(kt_rate_q);
    end else begin
      mul_x = tissue ? pt_q : pb_q;
      mul_r = tissue ? STEP_W'(kt_rate_q) : STEP_W'(kout);
    end
  end

  assign mul_p = mul_x * $signed({1'b0, mul_r});

  assign acc_rnd = ACC_W'(acc_q) + (ACC_W+1)'(32768);
  assign p_rnd   = (PROD_W+1)'(p_q) + (PROD_W+1)'(32768);
  assign deriv_s = sat_amt(42'(acc_rnd >>> SHIFT_W));
  assign slope_s = sat_amt(42'(p_rnd >>> SHIFT_W));

  // Next evaluation point: half slope for the middle stages, full slope after.
  assign inc_b = (stage == 2'd2) ? (AMT_W+1)'(kb_q) : ((AMT_W+1)'(kb_q) + 33'sd1) >>> 1;
  assign inc_t = (stage == 2'd2) ? (AMT_W+1)'(kt_q) : ((AMT_W+1)'(kt_q) + 33'sd1) >>> 1;
  assign pnt_b_s = sat_amt(42'(b_state_q) + 42'(inc_b));
  assign pnt_t_s = sat_amt(42'(t_state_q) + 42'(inc_t));

  always_comb begin
    sum_b_d = (stage == 2'd0) ? '0 : sum_b_q;
    sum_t_d = (stage == 2'd0) ? '0 : sum_t_q;
    if (stage[0] ^ stage[1]) begin
      sum_b_d = sum_b_d + (SUM_W'(kb_q) <<< 1);
      sum_t_d = sum_t_d + (SUM_W'(kt_q) <<< 1);
    end else begin
      sum_b_d = sum_b_d + SUM_W'(kb_q);
      sum_t_d = sum_t_d + SUM_W'(kt_q);
    end
  end

  assign fin_b_s = sat_amt(42'(b_state_q) + 42'(quo_b));
  assign fin_t_s = sat_amt(42'(t_state_q) + 42'(quo_t));

  rk4tc_div6 u_div_blood (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_b_d),
    .done_o  (div_done_b),
    .quo_o   (quo_b)
  );

  rk4tc_div6 u_div_tissue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_t_d),
    .done_o  (div_done_t),
    .quo_o   (quo_t)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser[0] == REQ_LOAD) ? ST_FIN : ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (phase_q == PH_SLOPE && tissue) begin
          state_d = ST_POINT;
        end
      end
      ST_POINT: state_d = last_stage ? ST_DIV : ST_SLOPE;
      ST_DIV: begin
        if (div_done_b && div_done_t) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    run_slope     = 1'b0;
    run_point     = 1'b0;
    div_start     = 1'b0;
    fin_upd       = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SLOPE: run_slope = 1'b1;
      ST_POINT: begin
        run_point = 1'b1;
        div_start = last_stage;
      end
      ST_DIV:   fin_upd = div_done_b && div_done_t;
      ST_FIN:   out_load = !m_valid_q || m_axis_tready;
      default:  s_axis_tready = 1'b0;
    endcase
  end

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_MUL_A;
      slope_q   <= '0;
      m_valid_q <= 1'b0;
      kb_rate_q <= 16'd6554;
      ke_rate_q <= 16'd13107;
      kt_rate_q <= 16'd26214;
      h_q       <= 24'd65536;
      b_state_q <= '0;
      t_state_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_RATE_B2T:  kb_rate_q <= cfg_data_i[RATE_W-1:0];
          CFG_RATE_ELIM: ke_rate_q <= cfg_data_i[RATE_W-1:0];
          CFG_RATE_T2B:  kt_rate_q <= cfg_data_i[RATE_W-1:0];
          CFG_STEP_SIZE: h_q       <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_q <= PH_MUL_A;
        slope_q <= '0;
        if (s_axis_tuser[0] == REQ_LOAD) begin
          b_state_q <= s_axis_tdata[31:0];
          t_state_q <= s_axis_tdata[63:32];
        end
      end
      if (run_slope) begin
        if (phase_q == PH_SLOPE) begin
          phase_q <= PH_MUL_A;
          if (!tissue) begin
            slope_q <= slope_q + 3'd1;
          end
        end else begin
          phase_q <= phase_q + 3'd1;
        end
      end
      if (run_point) begin
        slope_q <= slope_q + 3'd1;
      end
      if (fin_upd) begin
        b_state_q <= fin_b_s[AMT_W-1:0];
        t_state_q <= fin_t_s[AMT_W-1:0];
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sat_q <= 1'b0;
      pb_q  <= b_state_q;
      pt_q  <= t_state_q;
    end
    if (run_slope) begin
      if (phase_q == PH_MUL_A || phase_q == PH_MUL_B || phase_q == PH_MUL_H) begin
        p_q <= mul_p;
      end
      if (phase_q == PH_MUL_B) begin
        acc_q <= ACC_W'(p_q);
      end
      if (phase_q == PH_DIFF) begin
        acc_q <= acc_q - ACC_W'(p_q);
      end
      if (phase_q == PH_DERIV) begin
        d_q <= deriv_s[AMT_W-1:0];
        if (deriv_s[AMT_W]) begin
          sat_q <= 1'b1;
        end
      end
      if (phase_q == PH_SLOPE) begin
        if (tissue) begin
          kt_q <= slope_s[AMT_W-1:0];
        end else begin
          kb_q <= slope_s[AMT_W-1:0];
        end
        if (slope_s[AMT_W]) begin
          sat_q <= 1'b1;
        end
      end
    end
    if (run_point) begin
      sum_b_q <= sum_b_d;
      sum_t_q <= sum_t_d;
      pb_q    <= pnt_b_s[AMT_W-1:0];
      pt_q    <= pnt_t_s[AMT_W-1:0];
      if (!last_stage && (pnt_b_s[AMT_W] || pnt_t_s[AMT_W])) begin
        sat_q <= 1'b1;
      end
    end
    if (fin_upd && (fin_b_s[AMT_W] || fin_t_s[AMT_W])) begin
      sat_q <= 1'b1;
    end
    if (out_load) begin
      m_data_q <= {t_state_q, b_state_q};
      m_sat_q  <= sat_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_sat_q;

endmodule
